FILE: design/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants for the integer set table
// Holds the operation codes, the default capacity, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ist_pkg;

	// Field widths fixed by the transaction format.
	localparam int DATA_W = 32;
	localparam int OP_W = 3;

	// Default number of entries the set can hold.
	localparam int CAPACITY_DEF = 64;

	typedef logic [OP_W-1:0] opcode_t;

	// Operation codes.
	localparam opcode_t OP_INSERT = 3'd0;
	localparam opcode_t OP_REMOVE = 3'd1;
	localparam opcode_t OP_QUERY = 3'd2;
	localparam opcode_t OP_FIRST = 3'd3;
	localparam opcode_t OP_NEXT = 3'd4;

	// Read address select for the entry memory.
	typedef logic [1:0] rd_sel_t;
	localparam rd_sel_t RD_IDX = 2'd0;
	localparam rd_sel_t RD_IDX_NEXT = 2'd1;
	localparam rd_sel_t RD_WALK = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic idx_inc;
		logic rd_en;
		rd_sel_t rd_sel;
		logic wr_en;
		logic wr_shift;
		logic cnt_inc;
		logic cnt_dec;
		logic set_found;
		logic set_full;
		logic walk_clr;
		logic walk_inc;
		logic item_cap;
	} ist_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t op;
		logic idx_end;
		logic match;
		logic shift_more;
		logic walk_ok;
		logic full;
	} ist_sts_t;

endpackage

FILE: design/ist_ram.sv
// ----------------------------------------------------------------------------
// ist_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/ist_dp.sv
// ----------------------------------------------------------------------------
// ist_dp: datapath of the integer set table
// Holds the entry memory, the entry count, the scan index, the walk
// position and the result registers, and reports compare status.
// ----------------------------------------------------------------------------
module ist_dp
	import ist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input opcode_t opcode,
	input logic [DATA_W-1:0] value,
	input ist_cmd_t cmd,
	output ist_sts_t sts,
	output logic found,
	output logic item_valid,
	output logic [DATA_W-1:0] item_value,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic full_drop
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	opcode_t op_q;
	logic [DATA_W-1:0] value_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] walk_q;
	logic [CW-1:0] idx_next;
	logic found_q;
	logic full_q;
	logic item_valid_q;
	logic [DATA_W-1:0] item_value_q;
	logic [DATA_W-1:0] rd_data;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign idx_next = idx_q + ONE_C;

	// Transaction operands, captured on accept.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= opcode;
			value_q <= value;
		end
	end

	// Entry count, scan index and walk position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			walk_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + ONE_C;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - ONE_C;
			end
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_next;
			end
			if (cmd.walk_clr) begin
				walk_q <= '0;
			end else if (cmd.walk_inc) begin
				walk_q <= walk_q + ONE_C;
			end
		end
	end

	// Result registers, cleared at the start of each transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			full_q <= 1'b0;
			item_valid_q <= 1'b0;
			item_value_q <= '0;
		end else if (cmd.latch) begin
			found_q <= 1'b0;
			full_q <= 1'b0;
			item_valid_q <= 1'b0;
			item_value_q <= '0;
		end else begin
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
			if (cmd.item_cap) begin
				item_valid_q <= 1'b1;
				item_value_q <= rd_data;
			end
		end
	end

	// Memory address and data selection.
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX_NEXT: rd_addr = idx_next[AW-1:0];
			RD_WALK: rd_addr = walk_q[AW-1:0];
			default: rd_addr = idx_q[AW-1:0];
		endcase
		wr_addr = cmd.wr_shift ? idx_q[AW-1:0] : count_q[AW-1:0];
		wr_data = cmd.wr_shift ? rd_data : value_q;
	end

	ist_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.wr_en(cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Status back to the controller.
	always_comb begin
		sts.op = op_q;
		sts.idx_end = (idx_q == count_q);
		sts.match = (rd_data == value_q);
		sts.shift_more = (idx_next < count_q);
		sts.walk_ok = (walk_q < count_q);
		sts.full = (count_q == CAP_C);
	end

	assign found = found_q;
	assign full_drop = full_q;
	assign item_valid = item_valid_q;
	assign item_value = item_value_q;
	assign count = count_q;

	// The count never goes past the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count exceeds capacity");

	// An append only happens when there is room, and then the count grows.
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + ONE_C)
		else $error("append did not grow the count by one");

endmodule

FILE: design/ist_ctrl.sv
// ----------------------------------------------------------------------------
// ist_ctrl: controller of the integer set table
// Sequences the linear scan, the shift-down on remove, the append on insert
// and the walk reads, and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module ist_ctrl
	import ist_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input opcode_t opcode,
	input ist_sts_t sts,
	output ist_cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN_RD = 3'd1;
	localparam logic [2:0] S_SCAN_CMP = 3'd2;
	localparam logic [2:0] S_SHIFT_RD = 3'd3;
	localparam logic [2:0] S_SHIFT_WR = 3'd4;
	localparam logic [2:0] S_WALK_RD = 3'd5;
	localparam logic [2:0] S_WALK_CAP = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic accept;

	assign busy = !(state_q == S_IDLE || state_q == S_FINISH);
	assign done = (state_q == S_FINISH);
	assign accept = start && !busy;

	// Next state and commands.
	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_IDX;
		state_next = state_q;
		unique case (state_q)
			S_IDLE, S_FINISH: begin
				state_next = S_IDLE;
				if (accept) begin
					cmd.latch = 1'b1;
					unique case (opcode)
						OP_INSERT, OP_REMOVE, OP_QUERY: state_next = S_SCAN_RD;
						OP_FIRST: begin
							cmd.walk_clr = 1'b1;
							state_next = S_WALK_RD;
						end
						OP_NEXT: state_next = S_WALK_RD;
						default: state_next = S_FINISH;
					endcase
				end
			end
			S_SCAN_RD: begin
				if (sts.idx_end) begin
					// Value absent: append it on insert if there is room.
					if (sts.op == OP_INSERT) begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
						end else begin
							cmd.wr_en = 1'b1;
							cmd.cnt_inc = 1'b1;
						end
					end
					state_next = S_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_next = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					cmd.set_found = 1'b1;
					state_next = (sts.op == OP_REMOVE) ? S_SHIFT_RD : S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_next = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				// Move the following entry down, or close out the remove.
				if (sts.shift_more) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_IDX_NEXT;
					state_next = S_SHIFT_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_next = S_FINISH;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_shift = 1'b1;
				cmd.idx_inc = 1'b1;
				state_next = S_SHIFT_RD;
			end
			S_WALK_RD: begin
				if (sts.walk_ok) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_WALK;
					state_next = S_WALK_CAP;
				end else begin
					state_next = S_FINISH;
				end
			end
			S_WALK_CAP: begin
				cmd.item_cap = 1'b1;
				cmd.walk_inc = 1'b1;
				state_next = S_FINISH;
			end
			default: state_next = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// A shift write always follows the read of the entry it moves.
	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT_WR |-> $past(state_q) == S_SHIFT_RD)
		else $error("shift write without preceding read");

	// The single memory port pair is never asked to read and write at once.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("memory read and write issued together");

	// The walk only advances past an entry that exists.
	a_walk_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_inc |-> sts.walk_ok)
		else $error("walk advanced beyond the held entries");

	// A transaction taken while idle keeps the block busy in the next cycle,
	// except for a no-op, which goes straight to the result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy || done)
		else $error("accepted transaction did not proceed");

endmodule

FILE: design/integer_set_table_core.sv
// ----------------------------------------------------------------------------
// integer_set_table_core: bounded set of signed integers in insertion order
// Insert, remove and query read and compare the entries in order until a
// match or the end of the set; insert appends an absent value if there is
// room, remove shifts each later entry down and decrements the count.
// Iterate first and next read the walk entry, if any; unused codes finish.
// A new transaction is taken in the done cycle; the receiver cannot stall.
// Reset clears the count, the walk position and the results, not the memory.
// ----------------------------------------------------------------------------
module integer_set_table_core
	import ist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [OP_W-1:0] opcode,
	input logic signed [DATA_W-1:0] value,
	output logic done,
	output logic found,
	output logic item_valid,
	output logic signed [DATA_W-1:0] item_value,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic full_drop
);

	ist_cmd_t cmd;
	ist_sts_t sts;
	logic [DATA_W-1:0] item_value_raw;

	// Sequencer.
	ist_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	// Storage, counters and result registers.
	ist_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.opcode(opcode),
		.value(value),
		.cmd(cmd),
		.sts(sts),
		.found(found),
		.item_valid(item_valid),
		.item_value(item_value_raw),
		.count(count),
		.full_drop(full_drop)
	);

	assign item_value = item_value_raw;

endmodule
